>>> rtl/assert_macros.svh
// Assertion macros used by the checker module of the rotation basis block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/e2r_pkg.sv
// Package for the rotation basis block: widths, payload structs, CORDIC constants.
// No dependencies.
`default_nettype none
package e2r_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 15;
    localparam int OUT_W        = FRAC_BITS + 1;
    localparam int CORDIC_FRAC  = 30;
    localparam int CORDIC_ITERS = 28;
    localparam int CW           = 34;   // CORDIC datapath width
    localparam int ZW           = 33;   // residual angle width
    localparam int SC_W         = FRAC_BITS + 2;  // clamped sine/cosine, [-1, +1]
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] yaw_angle;
        logic [ANGLE_BITS-1:0] pitch_angle;
        logic [ANGLE_BITS-1:0] roll_angle;
    } in_beat_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] fwd_x;
        logic signed [OUT_W-1:0] fwd_y;
        logic signed [OUT_W-1:0] fwd_z;
        logic signed [OUT_W-1:0] left_x;
        logic signed [OUT_W-1:0] left_y;
        logic signed [OUT_W-1:0] left_z;
        logic signed [OUT_W-1:0] up_x;
        logic signed [OUT_W-1:0] up_y;
        logic signed [OUT_W-1:0] up_z;
    } out_beat_t;

    typedef struct packed {
        logic signed [SC_W-1:0] s;
        logic signed [SC_W-1:0] c;
    } sincos_t;

    function automatic logic signed [ZW-1:0] atan_turn(input int i);
        logic signed [ZW-1:0] t;
        case (i)
            0: t = 33'sd536870912;  1: t = 33'sd316933406;  2: t = 33'sd167458907;
            3: t = 33'sd85004756;   4: t = 33'sd42667331;   5: t = 33'sd21354465;
            6: t = 33'sd10680862;   7: t = 33'sd5340245;    8: t = 33'sd2670163;
            9: t = 33'sd1335087;    10: t = 33'sd667544;    11: t = 33'sd333772;
            12: t = 33'sd166886;    13: t = 33'sd83443;     14: t = 33'sd41722;
            15: t = 33'sd20861;     16: t = 33'sd10430;     17: t = 33'sd5215;
            18: t = 33'sd2608;      19: t = 33'sd1304;      20: t = 33'sd652;
            21: t = 33'sd326;       22: t = 33'sd163;       23: t = 33'sd81;
            24: t = 33'sd41;        25: t = 33'sd20;        26: t = 33'sd10;
            27: t = 33'sd5;
            default: t = '0;
        endcase
        return t;
    endfunction

    // Rounded Q product: floor((a*b + 2^(F-1)) / 2^F).
    function automatic logic signed [SC_W-1:0] mulq(input logic signed [SC_W-1:0] a,
                                                   input logic signed [SC_W-1:0] b);
        logic signed [2*SC_W-1:0] p;
        p = a * b + (2*SC_W)'(1 <<< (FRAC_BITS-1));
        return SC_W'(p >>> FRAC_BITS);
    endfunction

    // Saturate a sum to the output range.
    function automatic logic signed [OUT_W-1:0] sat(input logic signed [SC_W:0] v);
        logic signed [SC_W:0] hi;
        logic signed [SC_W:0] lo;
        hi = (SC_W+1)'((1 <<< FRAC_BITS) - 1);
        lo = -(SC_W+1)'(1 <<< FRAC_BITS);
        if (v > hi) return OUT_W'(hi);
        else if (v < lo) return OUT_W'(lo);
        else return OUT_W'(v);
    endfunction

endpackage
`default_nettype wire

>>> rtl/e2r_cordic.sv
// Pipelined rotation-mode CORDIC giving clamped sine and cosine of one binary angle.
// Depends on e2r_pkg. One iteration per register stage; stalls with the pipe enable.
`default_nettype none
module e2r_cordic (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic [e2r_pkg::ANGLE_BITS-1:0]    angle,
    output e2r_pkg::sincos_t                       sc
);
    localparam int N = e2r_pkg::CORDIC_ITERS;
    localparam int CW = e2r_pkg::CW;
    localparam int ZW = e2r_pkg::ZW;
    localparam int SH = e2r_pkg::CORDIC_FRAC - e2r_pkg::FRAC_BITS;

    logic signed [CW-1:0] x_reg [0:N];
    logic signed [CW-1:0] y_reg [0:N];
    logic signed [ZW-1:0] z_reg [0:N];
    logic                 neg_reg [0:N];
    logic [31:0]          a32;
    logic                 fold;
    logic [31:0]          a_res;
    e2r_pkg::sincos_t     sc_reg;
    e2r_pkg::sincos_t     sc_next;

    // The angle is folded into [-1/4, 1/4) turn; the folded half turn negates the result.
    always_comb
    begin
        a32   = {angle, {(32-e2r_pkg::ANGLE_BITS){1'b0}}};
        fold  = (a32[31:30] == 2'b01) || (a32[31:30] == 2'b10);
        a_res = fold ? (a32 - 32'h8000_0000) : a32;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= e2r_pkg::CORDIC_GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= ZW'(signed'(a_res));
            neg_reg[0] <= fold;
            for (int i = 0; i < N; i++)
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - e2r_pkg::atan_turn(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + e2r_pkg::atan_turn(i);
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    always_comb
    begin
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [CW-1:0] xr;
        logic signed [CW-1:0] yr;
        logic signed [CW-1:0] one;
        xs  = neg_reg[N] ? -x_reg[N] : x_reg[N];
        ys  = neg_reg[N] ? -y_reg[N] : y_reg[N];
        xr  = (xs + CW'(1 <<< (SH-1))) >>> SH;
        yr  = (ys + CW'(1 <<< (SH-1))) >>> SH;
        one = CW'(1 <<< e2r_pkg::FRAC_BITS);
        sc_next.c = (xr > one) ? e2r_pkg::SC_W'(one) : (xr < -one) ? e2r_pkg::SC_W'(-one)
                                                            : e2r_pkg::SC_W'(xr);
        sc_next.s = (yr > one) ? e2r_pkg::SC_W'(one) : (yr < -one) ? e2r_pkg::SC_W'(-one)
                                                            : e2r_pkg::SC_W'(yr);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg <= sc_next;
        end
    end

    assign sc = sc_reg;
endmodule
`default_nettype wire

>>> rtl/e2r_combine.sv
// Product and sum stages forming the nine basis components from sines and cosines.
// Depends on e2r_pkg. Three register stages: pair products, triple products, sums.
`default_nettype none
module e2r_combine (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  e2r_pkg::sincos_t          yaw_sc,
    input  e2r_pkg::sincos_t          pitch_sc,
    input  e2r_pkg::sincos_t          roll_sc,
    output e2r_pkg::out_beat_t        res
);
    localparam int W = e2r_pkg::SC_W;

    logic signed [W-1:0] cpcy_reg, cpsy_reg, sp_reg, cpsr_reg, cpcr_reg;
    logic signed [W-1:0] cysp_reg, sysp_reg, crcy_reg, crsy_reg, sr_reg;
    logic signed [W-1:0] crsy1_reg, crcy1_reg, srsy_reg, srcy_reg;
    logic signed [W-1:0] a3_reg, b3_reg, c3_reg, d3_reg, e3_reg, f3_reg;
    logic signed [W-1:0] q_cpcy_reg, q_cpsy_reg, q_sp_reg, q_cpsr_reg, q_cpcr_reg;
    e2r_pkg::out_beat_t  res_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cpcy_reg <= e2r_pkg::mulq(pitch_sc.c, yaw_sc.c);
            cpsy_reg <= e2r_pkg::mulq(pitch_sc.c, yaw_sc.s);
            cpsr_reg <= e2r_pkg::mulq(pitch_sc.c, roll_sc.s);
            cpcr_reg <= e2r_pkg::mulq(pitch_sc.c, roll_sc.c);
            cysp_reg <= e2r_pkg::mulq(yaw_sc.c, pitch_sc.s);
            sysp_reg <= e2r_pkg::mulq(yaw_sc.s, pitch_sc.s);
            crcy_reg <= e2r_pkg::mulq(roll_sc.c, yaw_sc.c);
            crsy_reg <= e2r_pkg::mulq(roll_sc.c, yaw_sc.s);
            srsy_reg <= e2r_pkg::mulq(roll_sc.s, yaw_sc.s);
            srcy_reg <= e2r_pkg::mulq(roll_sc.s, yaw_sc.c);
            sp_reg   <= pitch_sc.s;
            sr_reg   <= roll_sc.s;

            // Triple products take the second pair product times the third factor.
            a3_reg     <= e2r_pkg::mulq(cysp_reg, sr_reg);
            b3_reg     <= e2r_pkg::mulq(sysp_reg, sr_reg);
            c3_reg     <= e2r_pkg::mulq(crcy_reg, sp_reg);
            d3_reg     <= e2r_pkg::mulq(crsy_reg, sp_reg);
            crsy1_reg  <= crsy_reg;
            crcy1_reg  <= crcy_reg;
            e3_reg     <= srsy_reg;
            f3_reg     <= srcy_reg;
            q_cpcy_reg <= cpcy_reg;
            q_cpsy_reg <= cpsy_reg;
            q_sp_reg   <= sp_reg;
            q_cpsr_reg <= cpsr_reg;
            q_cpcr_reg <= cpcr_reg;

            res_reg.fwd_x  <= e2r_pkg::sat((W+1)'(q_cpcy_reg));
            res_reg.fwd_y  <= e2r_pkg::sat((W+1)'(q_cpsy_reg));
            res_reg.fwd_z  <= e2r_pkg::sat(-(W+1)'(q_sp_reg));
            res_reg.left_x <= e2r_pkg::sat((W+1)'(a3_reg) - (W+1)'(crsy1_reg));
            res_reg.left_y <= e2r_pkg::sat((W+1)'(b3_reg) + (W+1)'(crcy1_reg));
            res_reg.left_z <= e2r_pkg::sat((W+1)'(q_cpsr_reg));
            res_reg.up_x   <= e2r_pkg::sat((W+1)'(c3_reg) + (W+1)'(e3_reg));
            res_reg.up_y   <= e2r_pkg::sat((W+1)'(d3_reg) - (W+1)'(f3_reg));
            res_reg.up_z   <= e2r_pkg::sat((W+1)'(q_cpcr_reg));
        end
    end

    assign res = res_reg;
endmodule
`default_nettype wire

>>> rtl/euler_to_rotation_basis.sv
// Top level of the yaw-pitch-roll to rotation basis block.
// Depends on e2r_pkg, e2r_cordic and e2r_combine.
// Accepts one beat per cycle and delivers results through a pipe of 30 CORDIC
// stages and three product and sum stages, all advancing together. The whole
// pipe holds while the output beat waits, so throughput is one beat per cycle
// whenever the consumer keeps ready high.
`default_nettype none
module euler_to_rotation_basis (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  e2r_pkg::in_beat_t    in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output e2r_pkg::out_beat_t   out_data
);
    localparam int DEPTH = e2r_pkg::CORDIC_ITERS + 2 + 3;

    logic [DEPTH-1:0] vld_reg;
    logic             en;
    e2r_pkg::sincos_t ysc, psc, rsc;

    // The pipe advances unless the last stage holds a beat not yet taken.
    assign en       = !(vld_reg[DEPTH-1] && !out_ready);
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    e2r_cordic u_yaw   (.clk(clk), .en(en), .angle(in_data.yaw_angle),   .sc(ysc));
    e2r_cordic u_pitch (.clk(clk), .en(en), .angle(in_data.pitch_angle), .sc(psc));
    e2r_cordic u_roll  (.clk(clk), .en(en), .angle(in_data.roll_angle),  .sc(rsc));

    e2r_combine u_comb (
        .clk(clk), .en(en), .yaw_sc(ysc), .pitch_sc(psc), .roll_sc(rsc), .res(out_data)
    );

    assign out_valid = vld_reg[DEPTH-1];
endmodule
`default_nettype wire

>>> rtl/e2r_checker.sv
// Port-level checker for the rotation basis block, bound to the top level.
// Depends on e2r_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module e2r_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input e2r_pkg::out_beat_t      out_data
);
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid, in_ready)
    `ASSERT_IMPL(a_stall, clk, rst_n, out_valid && !out_ready, !in_ready)
    `ASSERT_IMPL(a_data_known, clk, rst_n, out_valid, !$isunknown(out_data))
endmodule

bind euler_to_rotation_basis e2r_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
